/* rtl/tfr_pkg.sv */
`timescale 1ns / 1ps

package tfr_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int POS_W       = $clog2(STORE_DEPTH);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 168;
  localparam int KIND_W     = 2;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] MAX_LENGTH  = 8'd25;
  localparam logic [7:0] CRC_POLY    = 8'h91;
  localparam logic [7:0] ID_SETUP    = 8'd254;
  localparam logic [7:0] ID_TELEM    = 8'd11;

  localparam int ID_POS           = 2;
  localparam int SETUP_STATUS_POS = 3;
  localparam int SETUP_CRC_SPAN   = 4;
  localparam int SETUP_CRC_POS    = 4;
  localparam int TELEM_CRC_SPAN   = 23;
  localparam int TELEM_CRC_POS    = 24;
  localparam int TELEM_FIRST_POS  = 3;
  localparam int TELEM_BYTES      = OUT_DATA_W / 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TELEM     = 2'd0,
    KIND_SETUP_ACK = 2'd1,
    KIND_DISCARD   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CRC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic crc_clr;
    logic crc_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic crc_last;
    logic out_free;
  } dp_status_t;

  // Reflected CRC-8, one byte folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = c ^ CRC_POLY;
      end
      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* rtl/tfr_datapath.sv */
`timescale 1ns / 1ps

module tfr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfr_pkg::dp_cmd_t                cmd_i,
  output tfr_pkg::dp_status_t             status_o,
  input  logic [tfr_pkg::IN_DATA_W-1:0]   rx_byte_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [tfr_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  output logic [tfr_pkg::KIND_W-1:0]      m_tuser_o
);

  localparam int PW = tfr_pkg::POS_W;

  logic [7:0]                      mem_q [tfr_pkg::STORE_DEPTH];
  logic [7:0]                      store_rd [tfr_pkg::STORE_DEPTH];
  logic [tfr_pkg::STORE_DEPTH-1:0] vld_q, vld_d;
  logic [PW-1:0]                   pos_q, pos_d, end_q, end_d;
  logic                            wr_en;
  logic                            frame_end;
  logic [7:0]                      crc_q, crc_d;
  logic [PW-1:0]                   idx_q, idx_d;
  logic [7:0]                      frame_id;
  logic                            crc_last;
  tfr_pkg::kind_e                  kind;
  logic [tfr_pkg::OUT_DATA_W-1:0]  result;
  logic                            out_vld_q;
  logic [tfr_pkg::OUT_DATA_W-1:0]  out_data_q;
  tfr_pkg::kind_e                  out_kind_q;

  // Unwritten entries read as zero.
  always_comb begin
    for (int k = 0; k < tfr_pkg::STORE_DEPTH; k++) begin
      store_rd[k] = vld_q[k] ? mem_q[k] : 8'd0;
    end
  end

  // Frame intake: header hunt, length, body up to the CRC byte.
  always_comb begin
    pos_d     = pos_q;
    end_d     = end_q;
    wr_en     = 1'b0;
    frame_end = 1'b0;
    if (pos_q == PW'(0)) begin
      if (rx_byte_i == tfr_pkg::HEADER_BYTE) begin
        wr_en = 1'b1;
        pos_d = PW'(1);
      end
    end else if (pos_q == PW'(1)) begin
      if (rx_byte_i > tfr_pkg::MAX_LENGTH) begin
        pos_d = '0;
        end_d = '0;
      end else begin
        wr_en = 1'b1;
        end_d = rx_byte_i[PW-1:0] + PW'(1);
        if (rx_byte_i == 8'd0) begin
          pos_d     = '0;
          frame_end = 1'b1;
        end else begin
          pos_d = PW'(2);
        end
      end
    end else if (pos_q <= end_q) begin
      wr_en = 1'b1;
      if (pos_q == end_q) begin
        pos_d     = '0;
        frame_end = 1'b1;
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end else begin
      pos_d = '0;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (cmd_i.load) begin
      vld_d = '0;
    end else if (cmd_i.take && wr_en) begin
      vld_d[pos_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      end_q <= '0;
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
      if (cmd_i.take) begin
        pos_q <= pos_d;
        end_q <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && wr_en) begin
      mem_q[pos_q] <= rx_byte_i;
    end
  end

  // CRC walk: one stored byte per cycle.
  always_comb begin
    crc_d = crc_q;
    idx_d = idx_q;
    if (cmd_i.crc_clr) begin
      crc_d = '0;
      idx_d = '0;
    end else if (cmd_i.crc_step) begin
      crc_d = tfr_pkg::crc8_byte(crc_q, store_rd[idx_q]);
      idx_d = idx_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      idx_q <= '0;
    end else begin
      crc_q <= crc_d;
      idx_q <= idx_d;
    end
  end

  assign frame_id = store_rd[tfr_pkg::ID_POS];

  always_comb begin
    if (frame_id == tfr_pkg::ID_SETUP) begin
      crc_last = (idx_q == PW'(tfr_pkg::SETUP_CRC_SPAN - 1));
    end else if (frame_id == tfr_pkg::ID_TELEM) begin
      crc_last = (idx_q == PW'(tfr_pkg::TELEM_CRC_SPAN - 1));
    end else begin
      crc_last = 1'b1;
    end
  end

  // Classify the finished frame; telemetry fields are bytes 3 up, little endian.
  always_comb begin
    kind   = tfr_pkg::KIND_DISCARD;
    result = '0;
    if (frame_id == tfr_pkg::ID_SETUP) begin
      if (crc_q == store_rd[tfr_pkg::SETUP_CRC_POS]
          && store_rd[tfr_pkg::SETUP_STATUS_POS] == 8'd1) begin
        kind = tfr_pkg::KIND_SETUP_ACK;
      end
    end else if (frame_id == tfr_pkg::ID_TELEM) begin
      if (crc_q == store_rd[tfr_pkg::TELEM_CRC_POS]) begin
        kind = tfr_pkg::KIND_TELEM;
        for (int k = 0; k < tfr_pkg::TELEM_BYTES; k++) begin
          result[k*8 +: 8] = store_rd[tfr_pkg::TELEM_FIRST_POS + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= result;
      out_kind_q <= kind;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;

  assign status_o.frame_end = frame_end;
  assign status_o.crc_last  = crc_last;
  assign status_o.out_free  = !out_vld_q || m_tready_i;

endmodule

/* rtl/tfr_ctrl.sv */
`timescale 1ns / 1ps

module tfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  tfr_pkg::dp_status_t status_i,
  output tfr_pkg::dp_cmd_t    cmd_o
);

  tfr_pkg::state_e state_q, state_d;
  logic            take;

  assign take = s_tvalid_i && (state_q == tfr_pkg::ST_RECV);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfr_pkg::ST_RECV: begin
        if (take && status_i.frame_end) begin
          state_d = tfr_pkg::ST_CRC;
        end
      end
      tfr_pkg::ST_CRC: begin
        if (status_i.crc_last) begin
          state_d = tfr_pkg::ST_EMIT;
        end
      end
      tfr_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = tfr_pkg::ST_RECV;
        end
      end
      default: begin
        state_d = tfr_pkg::ST_RECV;
      end
    endcase
  end

  always_comb begin
    s_tready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.crc_clr  = 1'b0;
    cmd_o.crc_step = 1'b0;
    cmd_o.load     = 1'b0;
    case (state_q)
      tfr_pkg::ST_RECV: begin
        s_tready_o    = 1'b1;
        cmd_o.take    = take;
        cmd_o.crc_clr = take && status_i.frame_end;
      end
      tfr_pkg::ST_CRC: begin
        cmd_o.crc_step = 1'b1;
      end
      tfr_pkg::ST_EMIT: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfr_pkg::ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/telemetry_frame_receiver.sv */
`timescale 1ns / 1ps

// Byte-stream deframer: hunts for header 0xFF, takes a length byte (0 to 25, larger
// restarts the hunt), stores the frame through its CRC byte and reports one result
// per completed frame on tuser: telemetry accepted (fields on tdata), setup
// acknowledged, or discarded (tdata zero). Bytes are taken one per cycle. After the
// byte that completes a frame the input is held off while a single CRC-8 byte unit
// walks the stored frame one byte per cycle (bytes 0 to 3 for a setup frame, 0 to 22
// for telemetry, only byte 0 for any other id), then the output register is loaded
// once the previous result has been taken or is being taken. The store is emptied
// when the output register is loaded.
module telemetry_frame_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [tfr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] sequence_number, [15:8] battery_status, [31:16] velocity_up,
  // [47:32] velocity_left, [63:48] velocity_forward, [79:64] heading_raw,
  // [95:80] altitude_raw, [111:96] pitch_raw, [127:112] roll_raw,
  // [159:128] engine_status_word, [167:160] fault_status
  output logic [tfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [1:0] frame_kind
  output logic [tfr_pkg::KIND_W-1:0]      m_axis_tuser_o
);

  tfr_pkg::dp_cmd_t    cmd;
  tfr_pkg::dp_status_t status;

  tfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .rx_byte_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  a_hold_after_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && status.frame_end) |=> !s_axis_tready_o)
    else $error("input taken during frame check");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == tfr_pkg::KIND_TELEM
                         || m_axis_tuser_o == tfr_pkg::KIND_SETUP_ACK
                         || m_axis_tuser_o == tfr_pkg::KIND_DISCARD))
    else $error("illegal frame kind");

  a_non_telem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != tfr_pkg::KIND_TELEM) |-> (m_axis_tdata_o == '0))
    else $error("non-telemetry result carries data");

endmodule
